### hdl/sdfa_pkg.sv
// Shared types and constants of the sparse DFA byte matcher.
// Table sizes, entry layouts, operation codes and sequencer states.
// No dependencies.
`default_nettype none

package sdfa_pkg;

	// Table sizes are powers of two; indices wrap in their natural width
	localparam int NUM_STATES      = 256;
	localparam int NUM_TRANSITIONS = 1024;
	localparam int LENGTH_BITS     = 16;

	localparam int MAP_DEPTH = 256;
	localparam int MAP_W     = $clog2(MAP_DEPTH);
	localparam int STATE_W   = $clog2(NUM_STATES);
	localparam int TRANS_W   = $clog2(NUM_TRANSITIONS);

	localparam int SYM_W   = 8;
	localparam int SIDX_W  = 8;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 9;
	localparam int OUTL_W  = 16;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	typedef enum logic [1:0] {
		OP_MAP   = 2'd0,
		OP_STATE = 2'd1,
		OP_TRANS = 2'd2,
		OP_MATCH = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_LOOKUP,
		SQ_SCAN,
		SQ_CHECK,
		SQ_EMIT
	} seq_state_t;

	typedef struct packed {
		logic               acc;
		logic [INDEX_W-1:0] first;
		logic [COUNT_W-1:0] count;
	} state_ent_t;

	typedef struct packed {
		logic              stops;
		logic [SIDX_W-1:0] next;
		logic [SYM_W-1:0]  sym;
	} trans_ent_t;

	typedef struct packed {
		logic               map_we;
		logic [MAP_W-1:0]   map_waddr;
		logic [SYM_W-1:0]   map_wdata;
		logic [MAP_W-1:0]   map_raddr;
		logic               state_we;
		logic [STATE_W-1:0] state_waddr;
		state_ent_t         state_wdata;
		logic [STATE_W-1:0] state_raddr;
		logic               trans_we;
		logic [TRANS_W-1:0] trans_waddr;
		trans_ent_t         trans_wdata;
		logic [TRANS_W-1:0] trans_raddr;
	} tbl_req_t;

	typedef struct packed {
		logic [SYM_W-1:0] map_sym;
		state_ent_t       state;
		trans_ent_t       trans;
	} tbl_rd_t;

	typedef struct packed {
		logic              valid;
		logic              matched;
		logic [OUTL_W-1:0] length;
	} res_t;

endpackage

`default_nettype wire

### hdl/sdfa_ifs.sv
// Channel interfaces of the sparse DFA byte matcher: input items and results.
// Valid/ready handshake with payload fields. Depends on nothing.
`default_nettype none

interface sdfa_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [9:0] table_index;
	logic [7:0] entry_symbol;
	logic       entry_accepting;
	logic [9:0] entry_first_transition;
	logic [8:0] entry_transition_count;
	logic [7:0] entry_next_state;
	logic       entry_stops;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source(output valid, operation, table_index, entry_symbol, entry_accepting,
		entry_first_transition, entry_transition_count, entry_next_state, entry_stops,
		byte_value, last_byte, input ready);
	modport sink(input valid, operation, table_index, entry_symbol, entry_accepting,
		entry_first_transition, entry_transition_count, entry_next_state, entry_stops,
		byte_value, last_byte, output ready);
endinterface

interface sdfa_out_if;
	logic        valid;
	logic        ready;
	logic        matched;
	logic [15:0] match_length;

	modport source(output valid, matched, match_length, input ready);
	modport sink(input valid, matched, match_length, output ready);
endinterface

`default_nettype wire

### hdl/sdfa_tables.sv
// Symbol map, state table and transition table memories.
// One write and one registered read per table per cycle. Uses sdfa_pkg.
`default_nettype none

module sdfa_tables (
	input  wire logic              clk,
	input  wire sdfa_pkg::tbl_req_t req,
	output sdfa_pkg::tbl_rd_t      rd
);

	logic [sdfa_pkg::SYM_W-1:0] map_mem   [sdfa_pkg::MAP_DEPTH];
	sdfa_pkg::state_ent_t       state_mem [sdfa_pkg::NUM_STATES];
	sdfa_pkg::trans_ent_t       trans_mem [sdfa_pkg::NUM_TRANSITIONS];

	always_ff @(posedge clk) begin
		if (req.map_we) begin
			map_mem[req.map_waddr] <= req.map_wdata;
		end
		rd.map_sym <= map_mem[req.map_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.state_we) begin
			state_mem[req.state_waddr] <= req.state_wdata;
		end
		rd.state <= state_mem[req.state_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.trans_we) begin
			trans_mem[req.trans_waddr] <= req.trans_wdata;
		end
		rd.trans <= trans_mem[req.trans_raddr];
	end

endmodule

`default_nettype wire

### hdl/sdfa_seq.sv
// Sequencer of the matcher: table writes, byte lookup and the transition scan.
// One compare unit checks one transition per cycle. Uses sdfa_pkg, sdfa_ifs.
`default_nettype none

module sdfa_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sdfa_in_if.sink                            in_ch,
	input  wire logic [sdfa_pkg::SIDX_W-1:0]   start_state,
	input  wire sdfa_pkg::tbl_rd_t             rd,
	output sdfa_pkg::tbl_req_t                 req,
	input  wire logic                          res_take,
	output sdfa_pkg::res_t                     res
);

	sdfa_pkg::seq_state_t fsm_q, fsm_d;

	logic [sdfa_pkg::SIDX_W-1:0]      cur_state_q;
	logic [sdfa_pkg::LENGTH_BITS-1:0] pos_q, pos1;
	logic                             verdict_q, at_start_q, last_q;
	logic [sdfa_pkg::SYM_W-1:0]       sym_q;
	logic                             acc_s_q;
	logic [sdfa_pkg::TRANS_W-1:0]     tidx_q;
	logic [sdfa_pkg::COUNT_W-1:0]     remain_q;
	logic                             res_matched_q;
	logic [sdfa_pkg::OUTL_W-1:0]      res_len_q;

	logic in_fire, is_match, skip_byte, hit;
	logic dec_done, dec_verdict, dec_matched;
	logic [sdfa_pkg::OUTL_W-1:0] dec_len;
	logic [sdfa_pkg::SIDX_W-1:0] base_state;

	assign in_fire   = in_ch.valid && in_ch.ready;
	assign is_match  = in_ch.operation == sdfa_pkg::OP_MATCH;
	assign skip_byte = verdict_q && !at_start_q;
	assign hit       = rd.trans.sym == sym_q;
	assign pos1      = (pos_q == sdfa_pkg::LEN_MAX) ? pos_q
		: pos_q + sdfa_pkg::LENGTH_BITS'(1);
	assign base_state = at_start_q ? start_state : cur_state_q;

	// next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			sdfa_pkg::SQ_IDLE: begin
				if (in_fire && is_match && !skip_byte) begin
					fsm_d = sdfa_pkg::SQ_LOOKUP;
				end
			end
			sdfa_pkg::SQ_LOOKUP: begin
				fsm_d = (rd.state.count == '0) ? sdfa_pkg::SQ_EMIT : sdfa_pkg::SQ_SCAN;
			end
			sdfa_pkg::SQ_SCAN: begin
				if (hit) begin
					fsm_d = rd.trans.stops ? sdfa_pkg::SQ_EMIT : sdfa_pkg::SQ_CHECK;
				end else if (remain_q == sdfa_pkg::COUNT_W'(1)) begin
					fsm_d = sdfa_pkg::SQ_EMIT;
				end
			end
			sdfa_pkg::SQ_CHECK: begin
				fsm_d = (rd.state.acc || last_q) ? sdfa_pkg::SQ_EMIT : sdfa_pkg::SQ_IDLE;
			end
			sdfa_pkg::SQ_EMIT: begin
				if (res_take) begin
					fsm_d = sdfa_pkg::SQ_IDLE;
				end
			end
			default: fsm_d = sdfa_pkg::SQ_IDLE;
		endcase
	end

	// outputs: table requests and the decision of the current step
	always_comb begin
		req = '0;
		dec_done    = 1'b0;
		dec_verdict = 1'b0;
		dec_matched = 1'b0;
		dec_len     = '0;

		req.map_waddr   = sdfa_pkg::MAP_W'(in_ch.table_index);
		req.map_wdata   = in_ch.entry_symbol;
		req.state_waddr = sdfa_pkg::STATE_W'(in_ch.table_index);
		req.state_wdata = '{acc: in_ch.entry_accepting, first: in_ch.entry_first_transition,
			count: in_ch.entry_transition_count};
		req.trans_waddr = sdfa_pkg::TRANS_W'(in_ch.table_index);
		req.trans_wdata = '{stops: in_ch.entry_stops, next: in_ch.entry_next_state,
			sym: in_ch.entry_symbol};
		req.map_raddr   = in_ch.byte_value;
		req.state_raddr = sdfa_pkg::STATE_W'(base_state);
		req.trans_raddr = tidx_q + sdfa_pkg::TRANS_W'(1);

		case (fsm_q)
			sdfa_pkg::SQ_IDLE: begin
				// drop writes beyond a table
				req.map_we = in_fire && in_ch.operation == sdfa_pkg::OP_MAP
					&& in_ch.table_index < sdfa_pkg::MAP_DEPTH;
				req.state_we = in_fire && in_ch.operation == sdfa_pkg::OP_STATE
					&& in_ch.table_index < sdfa_pkg::NUM_STATES;
				req.trans_we = in_fire && in_ch.operation == sdfa_pkg::OP_TRANS
					&& in_ch.table_index < sdfa_pkg::NUM_TRANSITIONS;
			end
			sdfa_pkg::SQ_LOOKUP: begin
				req.trans_raddr = sdfa_pkg::TRANS_W'(rd.state.first);
				if (rd.state.count == '0) begin
					dec_done    = 1'b1;
					dec_verdict = 1'b1;
					dec_matched = rd.state.acc;
				end
			end
			sdfa_pkg::SQ_SCAN: begin
				req.state_raddr = sdfa_pkg::STATE_W'(rd.trans.next);
				if (hit && rd.trans.stops) begin
					dec_done    = 1'b1;
					dec_verdict = 1'b1;
					dec_matched = acc_s_q;
					dec_len     = acc_s_q ? sdfa_pkg::OUTL_W'(pos1) : '0;
				end else if (!hit && remain_q == sdfa_pkg::COUNT_W'(1)) begin
					dec_done    = 1'b1;
					dec_verdict = 1'b1;
					dec_matched = acc_s_q;
				end
			end
			sdfa_pkg::SQ_CHECK: begin
				dec_done    = 1'b1;
				dec_verdict = rd.state.acc || last_q;
				dec_matched = rd.state.acc;
				dec_len     = rd.state.acc ? sdfa_pkg::OUTL_W'(pos1) : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= sdfa_pkg::SQ_IDLE;
			cur_state_q <= '0;
			pos_q       <= '0;
			verdict_q   <= 1'b0;
			at_start_q  <= 1'b1;
		end else begin
			fsm_q <= fsm_d;
			if (fsm_q == sdfa_pkg::SQ_IDLE && in_fire && is_match) begin
				if (at_start_q) begin
					cur_state_q <= start_state;
					pos_q       <= '0;
					verdict_q   <= 1'b0;
					at_start_q  <= 1'b0;
				end else if (verdict_q && in_ch.last_byte) begin
					// rearm on the last byte of an already decided string
					at_start_q <= 1'b1;
					verdict_q  <= 1'b0;
				end
			end
			if (fsm_q == sdfa_pkg::SQ_SCAN && hit && !rd.trans.stops) begin
				cur_state_q <= rd.trans.next;
			end
			if (dec_done) begin
				pos_q <= pos1;
				if (last_q) begin
					at_start_q <= 1'b1;
					verdict_q  <= 1'b0;
				end else if (dec_verdict) begin
					verdict_q <= 1'b1;
				end
			end
		end
	end

	// payload registers of the byte in flight
	always_ff @(posedge clk) begin
		if (fsm_q == sdfa_pkg::SQ_IDLE && in_fire) begin
			last_q <= in_ch.last_byte;
		end
		if (fsm_q == sdfa_pkg::SQ_LOOKUP) begin
			sym_q    <= rd.map_sym;
			acc_s_q  <= rd.state.acc;
			tidx_q   <= sdfa_pkg::TRANS_W'(rd.state.first);
			remain_q <= rd.state.count;
		end
		if (fsm_q == sdfa_pkg::SQ_SCAN) begin
			tidx_q   <= tidx_q + sdfa_pkg::TRANS_W'(1);
			remain_q <= remain_q - sdfa_pkg::COUNT_W'(1);
		end
		if (dec_done && dec_verdict) begin
			res_matched_q <= dec_matched;
			res_len_q     <= dec_len;
		end
	end

	assign in_ch.ready = fsm_q == sdfa_pkg::SQ_IDLE;
	assign res.valid   = fsm_q == sdfa_pkg::SQ_EMIT;
	assign res.matched = res_matched_q;
	assign res.length  = res_len_q;

endmodule

`default_nettype wire

### hdl/sparse_dfa_byte_matcher.sv
// Top level of the sparse DFA byte matcher: start-state register, result register,
// sequencer and table memories. Uses sdfa_pkg, sdfa_ifs, sdfa_tables, sdfa_seq.
//
//   port      dir  handshake        carries
//   in_ch     in   valid/ready      load entries or one string byte
//   out_ch    out  valid/ready      matched, match_length
//   cfg_wr_*  in   write enable     start_state
//
// A load item or a byte of an already decided string is taken without leaving SQ_IDLE.
// A scanned byte goes through SQ_LOOKUP, then SQ_SCAN for each transition examined, then
// SQ_CHECK when an ordinary transition is taken (next-state read) and SQ_EMIT when it gives
// a verdict; the single compare unit in the scan loop and one read port per table set these steps.
// The tables are not cleared by reset and must be loaded before matching.
// A verdict waits in the sequencer only while the result register is full and not taken.
`default_nettype none

module sparse_dfa_byte_matcher (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sdfa_in_if.sink         in_ch,
	sdfa_out_if.source      out_ch,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data
);

	logic [sdfa_pkg::SIDX_W-1:0] start_state_q;
	sdfa_pkg::tbl_req_t          req;
	sdfa_pkg::tbl_rd_t           rd;
	sdfa_pkg::res_t              res;
	logic                        res_take;
	logic                        out_valid_q;
	logic                        out_matched_q;
	logic [sdfa_pkg::OUTL_W-1:0] out_len_q;

	sdfa_tables u_tables (
		.clk (clk),
		.req (req),
		.rd  (rd)
	);

	sdfa_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.start_state (start_state_q),
		.rd          (rd),
		.req         (req),
		.res_take    (res_take),
		.res         (res)
	);

	assign res_take = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				start_state_q <= cfg_wr_data;
			end
			if (res_take) begin
				out_valid_q <= res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res.valid) begin
			out_matched_q <= res.matched;
			out_len_q     <= res.length;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.matched      = out_matched_q;
	assign out_ch.match_length = out_len_q;

endmodule

`default_nettype wire
